[rtl/oale_pkg.sv]
// ----------------------------------------------------------------------------
// oale_pkg
// shared types, codes and widths of the packed list engine
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int POS_W        = 6;
    localparam int CNT_OUT_W    = 6;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 32;

    // request operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND    = 2'd0,
        FN_INSERT    = 2'd1,
        FN_DEL_FIRST = 2'd2,
        FN_DEL_ALL   = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_POS   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_MATCH,
        S_WAVE,
        S_CLOSE,
        S_COMPACT
    } t_state;

    // per-cycle operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_MATCH,
        CELL_WAVE,
        CELL_CLOSE,
        CELL_COMPACT
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

[rtl/oale_cell.sv]
// ----------------------------------------------------------------------------
// oale_cell
// one list slot: holds an entry and trades it with its two neighbors
// ----------------------------------------------------------------------------
module oale_cell #(
    parameter int LEN_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  oale_pkg::t_cell_cmd         i_cmd,
    input  logic [LEN_W-1:0]            i_len,
    input  logic [LEN_W-1:0]            i_pos,
    input  logic [oale_pkg::DATA_W-1:0] i_prev_data,
    input  logic                        i_prev_mark,
    input  logic                        i_prev_cov,
    input  logic [oale_pkg::DATA_W-1:0] i_next_data,
    input  logic                        i_next_mark,
    input  logic                        i_next_tally,
    output logic [oale_pkg::DATA_W-1:0] o_data,
    output logic                        o_mark,
    output logic                        o_cov,
    output logic                        o_tally
);

    localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_IDX);

    logic [oale_pkg::DATA_W-1:0] r_data;
    logic                        r_hit;
    logic                        r_mark;
    logic                        r_cov;
    logic                        r_tally;
    logic                        w_in_len;
    logic                        w_hit;

    assign w_in_len = (IDX < i_len);
    assign w_hit    = w_in_len && (r_data == i_cmd.value);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            oale_pkg::CELL_LOAD: begin
                if (IDX == i_pos) begin
                    r_data <= i_cmd.value;
                end else if (IDX > i_pos) begin
                    r_data <= i_prev_data;
                end
            end
            oale_pkg::CELL_MATCH: begin
                r_hit   <= w_hit;
                r_mark  <= w_hit || !w_in_len;
                r_tally <= w_hit;
                r_cov   <= 1'b0;
            end
            oale_pkg::CELL_WAVE: begin
                r_cov <= i_prev_cov;
            end
            oale_pkg::CELL_CLOSE: begin
                if (r_cov || r_hit) begin
                    r_data <= i_next_data;
                end
            end
            oale_pkg::CELL_COMPACT: begin
                // hole below a kept entry: the two swap places
                if (r_mark && !i_next_mark) begin
                    r_data <= i_next_data;
                    r_mark <= 1'b0;
                end else if (i_prev_mark && !r_mark) begin
                    r_data <= i_prev_data;
                    r_mark <= 1'b1;
                end
                r_tally <= i_next_tally;
            end
            oale_pkg::CELL_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign o_data  = r_data;
    assign o_mark  = r_mark;
    assign o_cov   = r_cov || r_hit;
    assign o_tally = r_tally;

endmodule

[rtl/oale_ctrl.sv]
// ----------------------------------------------------------------------------
// oale_ctrl
// request sequencer: length count, pass counter and result register
// ----------------------------------------------------------------------------
module oale_ctrl #(
    parameter int CAPACITY = oale_pkg::DEF_CAPACITY,
    parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [oale_pkg::FUNC_W-1:0]    i_func,
    input  logic [oale_pkg::DATA_W-1:0]    i_value,
    input  logic [oale_pkg::POS_W-1:0]     i_position,
    input  logic                           i_found,
    input  logic                           i_tally0,
    output logic                           o_busy,
    output oale_pkg::t_cell_cmd            o_cmd,
    output logic [LEN_W-1:0]               o_len,
    output logic [LEN_W-1:0]               o_pos,
    output logic                           o_valid,
    output logic [oale_pkg::CNT_OUT_W-1:0] o_list_length,
    output logic [oale_pkg::STATUS_W-1:0]  o_status,
    output logic [oale_pkg::CNT_OUT_W-1:0] o_removed
);

    localparam int CNT_W = $clog2(CAPACITY);
    localparam int CMP_W = (LEN_W > oale_pkg::POS_W) ? LEN_W : oale_pkg::POS_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);

    oale_pkg::t_state                r_state, n_state;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [LEN_W-1:0]                r_len, n_len;
    logic [LEN_W-1:0]                r_gone, n_gone;
    oale_pkg::t_func                 r_func, n_func;
    logic [oale_pkg::DATA_W-1:0]     r_value, n_value;
    logic [oale_pkg::POS_W-1:0]      r_pos, n_pos;
    logic                            r_out_valid, n_out_valid;
    logic [LEN_W-1:0]                r_out_len, n_out_len;
    oale_pkg::t_status               r_out_status, n_out_status;
    logic [LEN_W-1:0]                r_out_removed, n_out_removed;

    logic                            w_full;
    logic                            w_bad_pos;
    logic [LEN_W-1:0]                w_gone_total;

    assign w_full       = (r_len == LEN_FULL);
    assign w_bad_pos    = (r_func == oale_pkg::FN_INSERT) &&
                          (CMP_W'(r_pos) > CMP_W'(r_len));
    assign w_gone_total = r_gone + LEN_W'(i_tally0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oale_pkg::S_IDLE: begin
                if (i_start) begin
                    if (oale_pkg::t_func'(i_func) == oale_pkg::FN_APPEND ||
                        oale_pkg::t_func'(i_func) == oale_pkg::FN_INSERT) begin
                        n_state = oale_pkg::S_INSERT;
                    end else begin
                        n_state = oale_pkg::S_MATCH;
                    end
                end
            end
            oale_pkg::S_INSERT: begin
                n_state = oale_pkg::S_IDLE;
            end
            oale_pkg::S_MATCH: begin
                if (r_func == oale_pkg::FN_DEL_FIRST) begin
                    n_state = oale_pkg::S_WAVE;
                end else begin
                    n_state = oale_pkg::S_COMPACT;
                end
            end
            oale_pkg::S_WAVE: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = oale_pkg::S_CLOSE;
                end
            end
            oale_pkg::S_CLOSE: begin
                n_state = oale_pkg::S_IDLE;
            end
            oale_pkg::S_COMPACT: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = oale_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oale_pkg::S_IDLE;
            end
        endcase
    end

    // cell command and handshake
    always_comb begin
        o_cmd.op    = oale_pkg::CELL_HOLD;
        o_cmd.value = r_value;
        o_pos       = LEN_W'(r_pos);
        unique case (r_state)
            oale_pkg::S_INSERT: begin
                if (!w_full && !w_bad_pos) begin
                    o_cmd.op = oale_pkg::CELL_LOAD;
                end
                if (r_func == oale_pkg::FN_APPEND) begin
                    o_pos = r_len;
                end
            end
            oale_pkg::S_MATCH:   o_cmd.op = oale_pkg::CELL_MATCH;
            oale_pkg::S_WAVE:    o_cmd.op = oale_pkg::CELL_WAVE;
            oale_pkg::S_CLOSE: begin
                if (i_found) begin
                    o_cmd.op = oale_pkg::CELL_CLOSE;
                end
            end
            oale_pkg::S_COMPACT: o_cmd.op = oale_pkg::CELL_COMPACT;
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != oale_pkg::S_IDLE);
    assign o_len  = r_len;

    // datapath next values
    always_comb begin
        n_cnt         = r_cnt;
        n_len         = r_len;
        n_gone        = r_gone;
        n_func        = r_func;
        n_value       = r_value;
        n_pos         = r_pos;
        n_out_valid   = 1'b0;
        n_out_len     = r_out_len;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        unique case (r_state)
            oale_pkg::S_IDLE: begin
                if (i_start) begin
                    n_func  = oale_pkg::t_func'(i_func);
                    n_value = i_value;
                    n_pos   = i_position;
                end
            end
            oale_pkg::S_INSERT: begin
                n_out_valid   = 1'b1;
                n_out_removed = '0;
                if (w_full) begin
                    n_out_status = oale_pkg::STAT_FULL;
                end else if (w_bad_pos) begin
                    n_out_status = oale_pkg::STAT_BAD_POS;
                end else begin
                    n_out_status = oale_pkg::STAT_OK;
                    n_len        = r_len + LEN_W'(1);
                end
                n_out_len = (!w_full && !w_bad_pos) ? r_len + LEN_W'(1) : r_len;
            end
            oale_pkg::S_MATCH: begin
                n_cnt  = '0;
                n_gone = '0;
            end
            oale_pkg::S_WAVE: begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            oale_pkg::S_CLOSE: begin
                n_out_valid = 1'b1;
                if (i_found) begin
                    n_len         = r_len - LEN_W'(1);
                    n_out_len     = r_len - LEN_W'(1);
                    n_out_status  = oale_pkg::STAT_OK;
                    n_out_removed = LEN_W'(1);
                end else begin
                    n_out_len     = r_len;
                    n_out_status  = oale_pkg::STAT_NOT_FOUND;
                    n_out_removed = '0;
                end
            end
            oale_pkg::S_COMPACT: begin
                n_cnt  = r_cnt + CNT_W'(1);
                n_gone = w_gone_total;
                if (r_cnt == CNT_LAST) begin
                    n_out_valid   = 1'b1;
                    n_len         = r_len - w_gone_total;
                    n_out_len     = r_len - w_gone_total;
                    n_out_removed = w_gone_total;
                    n_out_status  = (w_gone_total != '0) ? oale_pkg::STAT_OK
                                                         : oale_pkg::STAT_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oale_pkg::S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_gone      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_gone      <= n_gone;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_value       <= n_value;
        r_pos         <= n_pos;
        r_out_len     <= n_out_len;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
    end

    assign o_valid       = r_out_valid;
    assign o_list_length = oale_pkg::CNT_OUT_W'(r_out_len);
    assign o_status      = r_out_status;
    assign o_removed     = oale_pkg::CNT_OUT_W'(r_out_removed);

endmodule

[rtl/ordered_array_list_engine.sv]
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// packed list of signed words kept in a chain of slot cells
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake           | fields
// ---------+-----------+---------------------+------------------------------------
// request  | in        | start high, busy low| i_func, i_value, i_position
// result   | out       | o_valid, one cycle  | o_list_length, o_status, o_removed
//
// states per word, from accept to the next possible accept:
//   append / insert-at : insert
//   delete-first       : match, CAPACITY wave steps, close
//   delete-all         : match, CAPACITY compaction steps
// the delete passes are set by the chain length: the first-match marker and
// the hole/entry swaps move one cell per cycle
// synchronous reset clears the length count and the sequencer; entries are
// left as they are. the result strobe is registered and cannot be held off
//
module ordered_array_list_engine #(
    parameter int CAPACITY = oale_pkg::DEF_CAPACITY
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [oale_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [oale_pkg::DATA_W-1:0]    i_value,
    input  logic [oale_pkg::POS_W-1:0]            i_position,
    output logic                                  o_valid,
    output logic [oale_pkg::CNT_OUT_W-1:0]        o_list_length,
    output logic [oale_pkg::STATUS_W-1:0]         o_status,
    output logic [oale_pkg::CNT_OUT_W-1:0]        o_removed
);

    localparam int LEN_W = $clog2(CAPACITY + 1);

    oale_pkg::t_cell_cmd             w_cmd;
    logic [LEN_W-1:0]                w_len;
    logic [LEN_W-1:0]                w_pos;
    logic [oale_pkg::DATA_W-1:0]     w_data  [CAPACITY];
    logic                            w_mark  [CAPACITY];
    logic                            w_cov   [CAPACITY];
    logic                            w_tally [CAPACITY];

    // sequencer: owns the length, the pass counter and the result register
    oale_ctrl #(
        .CAPACITY (CAPACITY),
        .LEN_W    (LEN_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_found       (w_cov[CAPACITY-1]),   // marker reached the top cell
        .i_tally0      (w_tally[0]),          // hit bits drain out of cell 0
        .o_busy        (busy),
        .o_cmd         (w_cmd),
        .o_len         (w_len),
        .o_pos         (w_pos),
        .o_valid       (o_valid),
        .o_list_length (o_list_length),
        .o_status      (o_status),
        .o_removed     (o_removed)
    );

    // chain of slots: cell 0 holds the head of the list
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [oale_pkg::DATA_W-1:0] w_prev_data;
        logic                        w_prev_mark;
        logic                        w_prev_cov;
        logic [oale_pkg::DATA_W-1:0] w_next_data;
        logic                        w_next_mark;
        logic                        w_next_tally;

        if (g == 0) begin : g_head
            // nothing below the head: no hole, no match
            assign w_prev_data = '0;
            assign w_prev_mark = 1'b0;
            assign w_prev_cov  = 1'b0;
        end else begin : g_body_lo
            assign w_prev_data = w_data[g-1];
            assign w_prev_mark = w_mark[g-1];
            assign w_prev_cov  = w_cov[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            // beyond the last slot looks like a hole with no hit
            assign w_next_data  = '0;
            assign w_next_mark  = 1'b1;
            assign w_next_tally = 1'b0;
        end else begin : g_body_hi
            assign w_next_data  = w_data[g+1];
            assign w_next_mark  = w_mark[g+1];
            assign w_next_tally = w_tally[g+1];
        end

        oale_cell #(
            .LEN_W    (LEN_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_len        (w_len),
            .i_pos        (w_pos),
            .i_prev_data  (w_prev_data),
            .i_prev_mark  (w_prev_mark),
            .i_prev_cov   (w_prev_cov),
            .i_next_data  (w_next_data),
            .i_next_mark  (w_next_mark),
            .i_next_tally (w_next_tally),
            .o_data       (w_data[g]),
            .o_mark       (w_mark[g]),
            .o_cov        (w_cov[g]),
            .o_tally      (w_tally[g])
        );
    end

    // every result leaves the engine ready for the next word
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer still busy");

    // an accepted word always keeps the engine busy on the next cycle
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // a rejected or unmatched request removes nothing
    a_reject_none : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != oale_pkg::STAT_OK) |-> (o_removed == '0))
        else $error("entries removed on a failing request");

    // a removal always reports ok
    a_removed_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed != '0) |-> (o_status == oale_pkg::STAT_OK))
        else $error("entries removed without ok status");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the packed list engine: a directed table of
// requests covering empty, extreme values and every operation, then random
// sequences of fills up to full, drains and mixed traffic; each result word
// is checked against its typed row or a local model of every accepted request
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAP          = oale_pkg::DEF_CAPACITY;
    localparam int N_ITEMS      = 1400;
    localparam int QUIET_TAIL   = 200;   // last stretch of the run has no gaps
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 50;    // longer than the slowest request
    localparam int MAX_PRINTS   = 40;

    // one expected result word
    typedef struct packed {
        logic [oale_pkg::CNT_OUT_W-1:0] len;
        oale_pkg::t_status              st;
        logic [oale_pkg::CNT_OUT_W-1:0] removed;
    } t_outcome;

    // one row of the directed table
    typedef struct packed {
        oale_pkg::t_func                func;
        logic [oale_pkg::DATA_W-1:0]    value;
        logic [oale_pkg::POS_W-1:0]     position;
        logic                           typed;   // use the typed result, not the list model
        t_outcome                       result;
    } t_row;

    // dut inputs, all known from time zero
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           start         = 1'b0;
    logic                           busy;
    logic [oale_pkg::FUNC_W-1:0]    i_func        = '0;
    logic [oale_pkg::DATA_W-1:0]    i_value       = '0;
    logic [oale_pkg::POS_W-1:0]     i_position    = '0;
    logic                           o_valid;
    logic [oale_pkg::CNT_OUT_W-1:0] o_list_length;
    logic [oale_pkg::STATUS_W-1:0]  o_status;
    logic [oale_pkg::CNT_OUT_W-1:0] o_removed;

    // local copy of the list
    logic [oale_pkg::DATA_W-1:0] list_mem [CAP];
    int                          list_len = 0;

    t_outcome                    pending_results[$];
    t_row                        dir_rows[$];
    logic [oale_pkg::DATA_W-1:0] pool [4];

    int  words_sent   = 0;
    int  words_back   = 0;
    int  errors       = 0;
    int  stall_cycles = 0;
    int  status_hits [4];
    bit  gaps_on      = 1'b0;

    ordered_array_list_engine #(
        .CAPACITY      (CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_list_length (o_list_length),
        .o_status      (o_status),
        .o_removed     (o_removed)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // list model: applies one accepted request and returns its result word
    // ------------------------------------------------------------------------
    function automatic t_outcome apply_request(input oale_pkg::t_func f,
                                               input logic [oale_pkg::DATA_W-1:0] v,
                                               input logic [oale_pkg::POS_W-1:0] p);
        t_outcome r;
        int       i;
        int       hit;
        int       kept;
        r.st      = oale_pkg::STAT_OK;
        r.removed = '0;
        case (f)
            oale_pkg::FN_APPEND: begin
                if (list_len >= CAP) begin
                    r.st = oale_pkg::STAT_FULL;
                end else begin
                    list_mem[list_len] = v;
                    list_len++;
                end
            end
            oale_pkg::FN_INSERT: begin
                // full check wins over the position check
                if (list_len >= CAP) begin
                    r.st = oale_pkg::STAT_FULL;
                end else if (int'(p) > list_len) begin
                    r.st = oale_pkg::STAT_BAD_POS;
                end else begin
                    for (i = list_len; i > int'(p); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = v;
                    list_len++;
                end
            end
            oale_pkg::FN_DEL_FIRST: begin
                hit = -1;
                for (i = 0; i < list_len; i++)
                    if (hit < 0 && list_mem[i] == v)
                        hit = i;
                if (hit < 0) begin
                    r.st = oale_pkg::STAT_NOT_FOUND;
                end else begin
                    for (i = hit; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.removed = oale_pkg::CNT_OUT_W'(1);
                end
            end
            default: begin
                // compaction keeps the order of the survivors
                kept = 0;
                for (i = 0; i < list_len; i++)
                    if (list_mem[i] != v) begin
                        list_mem[kept] = list_mem[i];
                        kept++;
                    end
                r.removed = oale_pkg::CNT_OUT_W'(list_len - kept);
                r.st      = (list_len == kept) ? oale_pkg::STAT_NOT_FOUND
                                               : oale_pkg::STAT_OK;
                list_len  = kept;
            end
        endcase
        r.len = oale_pkg::CNT_OUT_W'(list_len);
        return r;
    endfunction

    function automatic t_row dir(input oale_pkg::t_func f,
                                 input logic [oale_pkg::DATA_W-1:0] v,
                                 input logic [oale_pkg::POS_W-1:0] p, input logic typed,
                                 input logic [oale_pkg::CNT_OUT_W-1:0] l,
                                 input oale_pkg::t_status s,
                                 input logic [oale_pkg::CNT_OUT_W-1:0] rm);
        t_row row;
        row.func     = f;
        row.value    = v;
        row.position = p;
        row.typed    = typed;
        row.result   = '{len: l, st: s, removed: rm};
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // request driver: called just after a rising edge, returns just after the
    // edge that accepted the word (or after a random gap that follows it)
    // ------------------------------------------------------------------------
    task automatic send_word(input oale_pkg::t_func f,
                             input logic [oale_pkg::DATA_W-1:0] v,
                             input logic [oale_pkg::POS_W-1:0] p, input logic typed,
                             input t_outcome typed_result);
        t_outcome predicted;
        start      <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        i_position <= p;
        // start is high from here on, so the first edge with busy low takes it
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        predicted = apply_request(f, v, p);
        pending_results.push_back(typed ? typed_result : predicted);
        words_sent++;
        // sender gap; start stays high otherwise, so back-to-back words never
        // lower and raise it in the same step
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // values for matching: a small pool so deletes hit, the list itself, noise
    function automatic logic [oale_pkg::DATA_W-1:0] pick_match_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return pool[$urandom_range(0, 3)];
        if (r < 85 && list_len > 0)
            return list_mem[$urandom_range(0, list_len - 1)];
        return $urandom;
    endfunction

    function automatic logic [oale_pkg::DATA_W-1:0] pick_store_value();
        if ($urandom_range(0, 99) < 65)
            return pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // insert position: mostly legal, now and then anywhere in the 6-bit range
    function automatic logic [oale_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(0, 9) == 0)
            return oale_pkg::POS_W'($urandom_range(0, 63));
        return oale_pkg::POS_W'($urandom_range(0, list_len));
    endfunction

    task automatic send_random(input oale_pkg::t_func f);
        logic [oale_pkg::DATA_W-1:0] v;
        logic [oale_pkg::POS_W-1:0]  p;
        if (f == oale_pkg::FN_DEL_FIRST || f == oale_pkg::FN_DEL_ALL)
            v = pick_match_value();
        else
            v = pick_store_value();
        // the position field is ignored except on insert-at, still toggle it
        p = (f == oale_pkg::FN_INSERT) ? pick_position()
                                       : oale_pkg::POS_W'($urandom_range(0, 63));
        send_word(f, v, p, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // result checker: the strobe lasts one cycle and cannot be held off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            words_back++;
            if (!$isunknown(o_status))
                status_hits[o_status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending, length",
                                int'(o_list_length), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_list_length !== want.len)
                    report_mismatch("list length", int'(o_list_length), int'(want.len));
                if (o_status !== want.st)
                    report_mismatch("status", int'(o_status), int'(want.st));
                if (o_removed !== want.removed)
                    report_mismatch("removed count", int'(o_removed), int'(want.removed));
            end
        end
    end

    // watchdog: a run with no handshake for too long is hung
    always @(posedge i_clk) begin
        if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         stall_cycles, pending_results.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int k;
        int steps;
        int r;

        // empty list: deletes miss, insert past the end is rejected
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'd5, 6'd0, 1'b1,
                               6'd0, oale_pkg::STAT_NOT_FOUND, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_ALL, 32'd5, 6'd0, 1'b1,
                               6'd0, oale_pkg::STAT_NOT_FOUND, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'd7, 6'd1, 1'b1,
                               6'd0, oale_pkg::STAT_BAD_POS, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'd7, 6'd0, 1'b1,
                               6'd1, oale_pkg::STAT_OK, 6'd0));
        // extreme values
        dir_rows.push_back(dir(oale_pkg::FN_APPEND, 32'h80000000, 6'd0, 1'b1,
                               6'd2, oale_pkg::STAT_OK, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_APPEND, 32'h7fffffff, 6'd63, 1'b1,
                               6'd3, oale_pkg::STAT_OK, 6'd0));
        // insert at position equal to length acts as append
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'hffffffff, 6'd3, 1'b1,
                               6'd4, oale_pkg::STAT_OK, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'd0, 6'd63, 1'b1,
                               6'd4, oale_pkg::STAT_BAD_POS, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'd5, 6'd0, 1'b1,
                               6'd5, oale_pkg::STAT_OK, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'd7, 6'd2, 1'b1,
                               6'd6, oale_pkg::STAT_OK, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_APPEND, 32'd7, 6'd0, 1'b1,
                               6'd7, oale_pkg::STAT_OK, 6'd0));
        // duplicates: delete-first takes one, delete-all takes the rest
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'd7, 6'd0, 1'b1,
                               6'd6, oale_pkg::STAT_OK, 6'd1));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_ALL, 32'd7, 6'd0, 1'b1,
                               6'd4, oale_pkg::STAT_OK, 6'd2));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_ALL, 32'd7, 6'd0, 1'b1,
                               6'd4, oale_pkg::STAT_NOT_FOUND, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'h7fffffff, 6'd0, 1'b1,
                               6'd3, oale_pkg::STAT_OK, 6'd1));
        // near miss: differs from -1 in the lowest bit only
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'hfffffffe, 6'd0, 1'b1,
                               6'd3, oale_pkg::STAT_NOT_FOUND, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'hffffffff, 6'd0, 1'b1,
                               6'd2, oale_pkg::STAT_OK, 6'd1));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'd5, 6'd0, 1'b1,
                               6'd1, oale_pkg::STAT_OK, 6'd1));
        dir_rows.push_back(dir(oale_pkg::FN_APPEND, 32'h80000000, 6'd0, 1'b1,
                               6'd2, oale_pkg::STAT_OK, 6'd0));
        // delete-all empties the list
        dir_rows.push_back(dir(oale_pkg::FN_DEL_ALL, 32'h80000000, 6'd0, 1'b1,
                               6'd0, oale_pkg::STAT_OK, 6'd2));
        dir_rows.push_back(dir(oale_pkg::FN_APPEND, 32'd0, 6'd42, 1'b1,
                               6'd1, oale_pkg::STAT_OK, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_DEL_FIRST, 32'd0, 6'd0, 1'b1,
                               6'd0, oale_pkg::STAT_OK, 6'd1));
        dir_rows.push_back(dir(oale_pkg::FN_APPEND, 32'h5a5a5a5a, 6'd63, 1'b0,
                               6'd0, oale_pkg::STAT_OK, 6'd0));
        dir_rows.push_back(dir(oale_pkg::FN_INSERT, 32'ha5a5a5a5, 6'd0, 1'b0,
                               6'd0, oale_pkg::STAT_OK, 6'd0));

        pool[0] = 32'h00000000;
        pool[1] = 32'hffffffff;
        pool[2] = 32'h80000000;
        pool[3] = 32'h7fffffff;

        // hold reset, then release it at an edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gaps_on = 1'b1;
        for (k = 0; k < dir_rows.size(); k++)
            send_word(dir_rows[k].func, dir_rows[k].value, dir_rows[k].position,
                      dir_rows[k].typed, dir_rows[k].result);

        // random sequences until the word budget is spent
        while (words_sent < N_ITEMS) begin
            gaps_on = (words_sent < N_ITEMS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
            pool[3] = $urandom;
            case ($urandom_range(0, 9))
                0, 1: begin
                    // fill to capacity, then knock on the full list
                    while (list_len < CAP)
                        send_random($urandom_range(0, 1) ? oale_pkg::FN_APPEND
                                                         : oale_pkg::FN_INSERT);
                    send_random(oale_pkg::FN_APPEND);
                    send_word(oale_pkg::FN_INSERT, $urandom,
                              oale_pkg::POS_W'($urandom_range(0, 63)), 1'b0, '0);
                    send_random($urandom_range(0, 1) ? oale_pkg::FN_DEL_FIRST
                                                     : oale_pkg::FN_DEL_ALL);
                end
                2: begin
                    // drain with values taken from the list, then miss on empty
                    steps = 0;
                    while (list_len > 0 && steps < 40) begin
                        send_word($urandom_range(0, 3) ? oale_pkg::FN_DEL_FIRST
                                                       : oale_pkg::FN_DEL_ALL,
                                  list_mem[$urandom_range(0, list_len - 1)],
                                  oale_pkg::POS_W'($urandom_range(0, 63)), 1'b0, '0);
                        steps++;
                    end
                    send_random($urandom_range(0, 1) ? oale_pkg::FN_DEL_FIRST
                                                     : oale_pkg::FN_DEL_ALL);
                end
                default: begin
                    // mixed traffic, slightly biased toward growth
                    repeat ($urandom_range(4, 20)) begin
                        r = $urandom_range(0, 99);
                        if (r < 35)
                            send_random(oale_pkg::FN_APPEND);
                        else if (r < 65)
                            send_random(oale_pkg::FN_INSERT);
                        else if (r < 85)
                            send_random(oale_pkg::FN_DEL_FIRST);
                        else
                            send_random(oale_pkg::FN_DEL_ALL);
                    end
                end
            endcase
        end

        start <= 1'b0;

        // every word gets its result, then a quiet tail for stray strobes
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d request words, %0d result words, %0d mismatches",
                 words_sent, words_back, errors);
        $display("run: status ok %0d, full %0d, not found %0d, bad position %0d",
                 status_hits[oale_pkg::STAT_OK], status_hits[oale_pkg::STAT_FULL],
                 status_hits[oale_pkg::STAT_NOT_FOUND],
                 status_hits[oale_pkg::STAT_BAD_POS]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
